// File: hw/rtl/cps_pkg.sv
// Shared types and constants for the request path segment parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package cps_pkg;

  localparam int unsigned MAX_PATH_BYTES = 510;
  localparam int unsigned OFF_W = 9;

  localparam logic [7:0] SYM_SEGMENT = 8'h91;
  localparam logic [7:0] DOT_CHAR    = 8'h2E;

  localparam logic [2:0] KIND_CLASS     = 3'd0;
  localparam logic [2:0] KIND_INSTANCE  = 3'd1;
  localparam logic [2:0] KIND_ATTRIBUTE = 3'd2;
  localparam logic [2:0] KIND_CONN_PT   = 3'd3;
  localparam logic [2:0] KIND_ELEMENT   = 3'd4;
  localparam logic [2:0] KIND_NAME_CHAR = 3'd5;
  localparam logic [2:0] KIND_END       = 3'd6;

  localparam logic [1:0] RSN_COMPLETE  = 2'd0;
  localparam logic [1:0] RSN_UNKNOWN   = 2'd1;
  localparam logic [1:0] RSN_TRUNCATED = 2'd2;
  localparam logic [1:0] RSN_FORMAT    = 2'd3;

  localparam logic [2:0] LT_CLASS     = 3'd0;
  localparam logic [2:0] LT_INSTANCE  = 3'd1;
  localparam logic [2:0] LT_ELEMENT   = 3'd2;
  localparam logic [2:0] LT_CONN_PT   = 3'd3;
  localparam logic [2:0] LT_ATTRIBUTE = 3'd4;

  localparam logic [1:0] REG_PATH_LENGTH = 2'd0;

  typedef enum logic [2:0] {
    PH_SEG       = 3'd0,
    PH_SYM_COUNT = 3'd1,
    PH_SYM_CHARS = 3'd2,
    PH_SYM_PAD   = 3'd3,
    PH_LOG_PAD   = 3'd4,
    PH_LOG_VALUE = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] path_byte;
    logic       start_of_path;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [8:0]  consumed;
    logic [1:0]  stop_reason;
    logic        last;
  } out_t;

  typedef struct packed {
    phase_t           phase;
    logic [OFF_W-1:0] byte_offset;
    logic [31:0]      value_accumulator;
    logic [2:0]       value_bytes_left;
    logic [2:0]       segment_logical_type;
    logic [7:0]       name_chars_left;
    logic             name_pad_pending;
    logic             seen_symbolic;
    logic             parse_stopped;
    logic [2:0]       value_width;
  } st_t;

  localparam st_t ST_RESET = '{
    phase: PH_SEG, byte_offset: '0, value_accumulator: '0, value_bytes_left: '0,
    segment_logical_type: '0, name_chars_left: '0, name_pad_pending: 1'b0,
    seen_symbolic: 1'b0, parse_stopped: 1'b0, value_width: '0
  };

  typedef struct packed {
    logic [1:0] cnt;
    out_t       r0;
    out_t       r1;
  } step_res_t;

endpackage

// File: hw/rtl/cps_step.sv
// Next-state and result logic for one path byte.
// Depends on cps_pkg.
`timescale 1ns / 1ps
module cps_step import cps_pkg::*; (
  input  st_t              st_i,
  input  in_t              in_i,
  input  logic [OFF_W-1:0] len_i,
  output st_t              st_o,
  output step_res_t        res_o
);

  st_t              s;
  st_t              nx;
  logic [OFF_W-1:0] off;
  logic [OFF_W-1:0] pos;
  logic [OFF_W-1:0] end_cons;
  logic [1:0]       end_rsn;
  logic             end_vld;
  logic             item_vld;
  out_t             item;
  out_t             end_item;
  logic [7:0]       b;
  logic [2:0]       width;
  logic             pad;
  logic [31:0]      acc;
  logic [31:0]      v;
  logic [7:0]       chars_left;

  always_comb begin
    s        = in_i.start_of_path ? ST_RESET : st_i;
    nx       = s;
    b        = in_i.path_byte;
    off      = s.byte_offset + OFF_W'(1);
    end_vld  = 1'b0;
    end_cons = s.byte_offset;
    end_rsn  = RSN_COMPLETE;
    item_vld = 1'b0;
    item     = '0;
    width    = 3'd1;
    pad      = 1'b0;
    pos      = off;
    acc      = '0;
    v        = '0;
    chars_left = '0;

    if (!in_i.start_of_path && st_i.parse_stopped) begin
      nx = st_i;
    end else if (s.byte_offset >= len_i) begin
      end_vld  = 1'b1;
      end_cons = s.byte_offset;
      end_rsn  = (s.phase == PH_SEG || s.phase == PH_SYM_PAD) ? RSN_COMPLETE : RSN_TRUNCATED;
    end else begin
      nx.byte_offset = off;
      case (s.phase)
        PH_SEG: begin
          if (b == SYM_SEGMENT) begin
            nx.phase = PH_SYM_COUNT;
            if (off >= len_i) begin
              end_vld  = 1'b1;
              end_cons = off;
              end_rsn  = RSN_TRUNCATED;
            end
          end else if (b[7:5] != 3'b001) begin
            nx.byte_offset = s.byte_offset;
            end_vld  = 1'b1;
            end_cons = s.byte_offset;
            end_rsn  = RSN_UNKNOWN;
          end else begin
            nx.segment_logical_type = b[4:2];
            if (b[1:0] == 2'd3) begin
              end_vld  = 1'b1;
              end_cons = off;
              end_rsn  = RSN_FORMAT;
            end else begin
              width = (b[1:0] == 2'd0) ? 3'd1 : ((b[1:0] == 2'd1) ? 3'd2 : 3'd4);
              pad   = (width != 3'd1) && off[0];
              pos   = off + {{(OFF_W-1){1'b0}}, pad};
              nx.value_width = width;
              if (({1'b0, pos} + {{(OFF_W-2){1'b0}}, width}) > {1'b0, len_i}) begin
                nx.byte_offset = pos;
                end_vld  = 1'b1;
                end_cons = pos;
                end_rsn  = RSN_TRUNCATED;
              end else begin
                nx.value_accumulator = '0;
                nx.value_bytes_left  = width;
                nx.phase = pad ? PH_LOG_PAD : PH_LOG_VALUE;
              end
            end
          end
        end
        PH_SYM_COUNT: begin
          if (({1'b0, off} + {{(OFF_W-7){1'b0}}, b}) > {1'b0, len_i}) begin
            end_vld  = 1'b1;
            end_cons = off;
            end_rsn  = RSN_TRUNCATED;
          end else begin
            if (s.seen_symbolic) begin
              item_vld   = 1'b1;
              item.kind  = KIND_NAME_CHAR;
              item.value = {24'd0, DOT_CHAR};
            end
            nx.seen_symbolic    = 1'b1;
            nx.name_chars_left  = b;
            nx.name_pad_pending = b[0];
            nx.phase = (b == 8'd0) ? PH_SEG : PH_SYM_CHARS;
          end
        end
        PH_SYM_CHARS: begin
          item_vld   = 1'b1;
          item.kind  = KIND_NAME_CHAR;
          item.value = {24'd0, b};
          chars_left = s.name_chars_left - 8'd1;
          nx.name_chars_left = chars_left;
          if (chars_left == 8'd0) begin
            if (s.name_pad_pending) begin
              nx.name_pad_pending = 1'b0;
              if (off >= len_i) begin
                nx.byte_offset = off + OFF_W'(1);
                end_vld  = 1'b1;
                end_cons = off + OFF_W'(1);
                end_rsn  = RSN_COMPLETE;
              end else begin
                nx.phase = PH_SYM_PAD;
              end
            end else begin
              nx.phase = PH_SEG;
            end
          end
        end
        PH_SYM_PAD: nx.phase = PH_SEG;
        PH_LOG_PAD: nx.phase = PH_LOG_VALUE;
        PH_LOG_VALUE: begin
          acc = {b, s.value_accumulator[31:8]};
          nx.value_accumulator = acc;
          nx.value_bytes_left  = s.value_bytes_left - 3'd1;
          if (nx.value_bytes_left == 3'd0) begin
            case (s.value_width)
              3'd1:    v = acc >> 24;
              3'd2:    v = acc >> 16;
              default: v = acc;
            endcase
            case (s.segment_logical_type)
              LT_CLASS: begin
                item_vld = 1'b1; item.kind = KIND_CLASS; item.value = v;
              end
              LT_INSTANCE: begin
                item_vld = 1'b1; item.kind = KIND_INSTANCE; item.value = v;
              end
              LT_ELEMENT: begin
                item_vld = 1'b1; item.kind = KIND_ELEMENT; item.value = v;
              end
              LT_CONN_PT: begin
                item_vld = 1'b1; item.kind = KIND_CONN_PT; item.value = {16'd0, v[15:0]};
              end
              LT_ATTRIBUTE: begin
                item_vld = 1'b1; item.kind = KIND_ATTRIBUTE; item.value = {16'd0, v[15:0]};
              end
              default: item_vld = 1'b0;
            endcase
            nx.phase = PH_SEG;
          end
        end
        default: nx.phase = PH_SEG;
      endcase
      if (!end_vld && nx.phase == PH_SEG && nx.byte_offset >= len_i) begin
        end_vld  = 1'b1;
        end_cons = nx.byte_offset;
        end_rsn  = RSN_COMPLETE;
      end
    end

    if (end_vld) begin
      nx.parse_stopped = 1'b1;
    end

    end_item             = '0;
    end_item.kind        = KIND_END;
    end_item.consumed    = (end_cons > len_i) ? len_i : end_cons;
    end_item.stop_reason = end_rsn;
    end_item.last        = 1'b1;

    st_o       = nx;
    res_o.cnt  = {1'b0, item_vld} + {1'b0, end_vld};
    res_o.r0   = item_vld ? item : end_item;
    res_o.r1   = end_item;
  end

endmodule

// File: hw/rtl/cps_outq.sv
// Four-entry result queue: takes up to two results per cycle, hands out one.
// Depends on cps_pkg.
`timescale 1ns / 1ps
module cps_outq import cps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  step_res_t res_i,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_t      out_data
);

  out_t       mem_r [4];
  logic [1:0] wr_r;
  logic [1:0] wr_nxt;
  logic [1:0] rd_r;
  logic [1:0] rd_nxt;
  logic [2:0] cnt_r;
  logic [2:0] cnt_nxt;
  logic [1:0] n_push;
  logic       pop;

  assign room      = (cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = mem_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign n_push    = push ? res_i.cnt : 2'd0;
  assign wr_nxt    = wr_r + n_push;
  assign rd_nxt    = rd_r + {1'b0, pop};
  assign cnt_nxt   = cnt_r + {1'b0, n_push} - {2'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_r] <= res_i.r0;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_r + 2'd1] <= res_i.r1;
    end
  end

endmodule

// File: hw/rtl/cip_path_segment_parser.sv
// Request path segment parser: one path byte per cycle, results to a queue.
// Each result is written into the result queue when its byte is accepted and is offered from the queue head.
// Throughput: one byte per cycle while the four-entry result queue has at least two free slots.
// Reset (rst_n low, synchronous): parser at offset zero, path_length = 2, queue empty.
// Depends on cps_pkg, cps_step, cps_outq.
`timescale 1ns / 1ps
module cip_path_segment_parser import cps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  st_t              st_r;
  st_t              st_nxt;
  step_res_t        res;
  logic [OFF_W-1:0] path_length_r;
  logic [OFF_W-1:0] len;
  logic             room;
  logic             in_acc;

  assign pready = 1'b1;
  assign prdata = {{(32-OFF_W){1'b0}}, path_length_r};
  assign len    = (path_length_r > OFF_W'(MAX_PATH_BYTES)) ? OFF_W'(MAX_PATH_BYTES)
                                                           : path_length_r;
  assign in_ready = room;
  assign in_acc   = in_valid && room;

  cps_step u_step (
    .st_i  (st_r),
    .in_i  (in_data),
    .len_i (len),
    .st_o  (st_nxt),
    .res_o (res)
  );

  cps_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .res_i     (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= ST_RESET;
      path_length_r <= OFF_W'(2);
    end else begin
      if (in_acc) begin
        st_r <= st_nxt;
      end
      if (psel && penable && pwrite && pready && paddr == REG_PATH_LENGTH) begin
        path_length_r <= pwdata[OFF_W-1:0];
      end
    end
  end

endmodule

// File: dv/cps_parse_checker.sv
// Result checker for cip_path_segment_parser: watches the byte, result and
// register ports, predicts every result of the path parse and compares them.
// Depends on cps_pkg for the port types, kind, reason and phase codes.
`timescale 1ns / 1ps
module cps_parse_checker import cps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          errors,
  output int          parsed_pending,
  output int          results_seen,
  output int          ends_seen,
  output logic [3:0]  reasons_hit
);

  localparam logic [1:0] LEN_ADDR    = 2'(32'(REG_PATH_LENGTH) * 4);
  localparam logic [2:0] SEG_LOGICAL = 3'b001;

  logic [8:0]  plen;
  phase_t      ph;
  int unsigned offs;
  logic [31:0] acc;
  int unsigned left;
  int unsigned vwidth;
  int unsigned chars;
  logic [2:0]  ltype;
  logic        pad_pend;
  logic        seen_sym;
  logic        stopped;

  out_t parsed_q[$];

  initial begin
    errors = 0;
    parsed_pending = 0;
    results_seen = 0;
    ends_seen = 0;
    reasons_hit = '0;
  end

  task automatic report(string msg);
    $display("[%0t] %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
    end
  endtask

  function automatic void restart_parse();
    ph = PH_SEG;
    offs = 0;
    acc = '0;
    left = 0;
    vwidth = 0;
    chars = 0;
    ltype = '0;
    pad_pend = 1'b0;
    seen_sym = 1'b0;
    stopped = 1'b0;
  endfunction

  function automatic void emit(logic [2:0] kind, logic [31:0] value, logic [8:0] used,
                               logic [1:0] reason, logic last);
    out_t r;
    r.kind = kind;
    r.value = value;
    r.consumed = used;
    r.stop_reason = reason;
    r.last = last;
    parsed_q.push_back(r);
  endfunction

  function automatic void close_run(int unsigned len, logic [1:0] reason);
    int unsigned used;
    used = (offs > len) ? len : offs;
    stopped = 1'b1;
    emit(KIND_END, '0, 9'(used), reason, 1'b1);
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic sop);
    int unsigned len, off, pos, pad;
    logic [31:0] v;
    len = 32'(plen);
    if (len > MAX_PATH_BYTES) len = MAX_PATH_BYTES;
    if (sop) begin
      restart_parse();
    end else if (stopped) begin
      return;
    end
    // byte past the length: close, complete only between segments or at a pad
    if (offs >= len) begin
      close_run(len, (ph == PH_SEG || ph == PH_SYM_PAD) ? RSN_COMPLETE : RSN_TRUNCATED);
      return;
    end
    off = offs + 1;
    offs = off;
    case (ph)
      PH_SEG: begin
        if (b == SYM_SEGMENT) begin
          ph = PH_SYM_COUNT;
          if (off >= len) close_run(len, RSN_TRUNCATED);
          return;
        end
        if (b[7:5] != SEG_LOGICAL) begin
          offs = off - 1;
          close_run(len, RSN_UNKNOWN);
          return;
        end
        ltype = b[4:2];
        if (&b[1:0]) begin
          close_run(len, RSN_FORMAT);
          return;
        end
        vwidth = 32'(1) << b[1:0];
        pad = (vwidth > 1 && off[0]) ? 1 : 0;
        pos = off + pad;
        if (pos + vwidth > len) begin
          offs = pos;
          close_run(len, RSN_TRUNCATED);
          return;
        end
        acc = '0;
        left = vwidth;
        ph = (pad != 0) ? PH_LOG_PAD : PH_LOG_VALUE;
        return;
      end
      PH_SYM_COUNT: begin
        if (off + 32'(b) > len) begin
          close_run(len, RSN_TRUNCATED);
          return;
        end
        if (seen_sym) emit(KIND_NAME_CHAR, {24'b0, DOT_CHAR}, '0, RSN_COMPLETE, 1'b0);
        seen_sym = 1'b1;
        chars = 32'(b);
        pad_pend = b[0];
        ph = (b == 8'd0) ? PH_SEG : PH_SYM_CHARS;
      end
      PH_SYM_CHARS: begin
        emit(KIND_NAME_CHAR, {24'b0, b}, '0, RSN_COMPLETE, 1'b0);
        chars = chars - 1;
        if (chars == 0) begin
          if (pad_pend) begin
            pad_pend = 1'b0;
            // odd name ending the path: the missing pad still counts
            if (off >= len) begin
              offs = off + 1;
              close_run(len, RSN_COMPLETE);
              return;
            end
            ph = PH_SYM_PAD;
          end else begin
            ph = PH_SEG;
          end
        end
      end
      PH_SYM_PAD: ph = PH_SEG;
      PH_LOG_PAD: ph = PH_LOG_VALUE;
      default: begin
        acc = {b, acc[31:8]};
        left = left - 1;
        if (left == 0) begin
          v = acc >> (8 * (4 - vwidth));
          case (ltype)
            LT_CLASS:     emit(KIND_CLASS, v, '0, RSN_COMPLETE, 1'b0);
            LT_INSTANCE:  emit(KIND_INSTANCE, v, '0, RSN_COMPLETE, 1'b0);
            LT_ELEMENT:   emit(KIND_ELEMENT, v, '0, RSN_COMPLETE, 1'b0);
            LT_CONN_PT:   emit(KIND_CONN_PT, {16'b0, v[15:0]}, '0, RSN_COMPLETE, 1'b0);
            LT_ATTRIBUTE: emit(KIND_ATTRIBUTE, {16'b0, v[15:0]}, '0, RSN_COMPLETE, 1'b0);
            default: ;
          endcase
          ph = PH_SEG;
        end
      end
    endcase
    if (ph == PH_SEG && offs >= len) close_run(len, RSN_COMPLETE);
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      plen = 9'd2;
      restart_parse();
      parsed_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (parsed_q.size() == 0) begin
          report($sformatf("result with nothing pending: kind %0d value %0h",
                           out_data.kind, out_data.value));
        end else begin
          want = parsed_q.pop_front();
          check_field("kind", 32'(out_data.kind), 32'(want.kind));
          check_field("value", out_data.value, want.value);
          check_field("consumed", 32'(out_data.consumed), 32'(want.consumed));
          check_field("stop_reason", 32'(out_data.stop_reason), 32'(want.stop_reason));
          check_field("last", 32'(out_data.last), 32'(want.last));
          results_seen++;
          if (want.last) begin
            ends_seen++;
            reasons_hit[want.stop_reason] = 1'b1;
          end
        end
      end
      if (psel && penable && pready && paddr == LEN_ADDR) begin
        if (pwrite) begin
          plen = pwdata[8:0];
        end else begin
          check_field("path_length readback", prdata, 32'(plen));
        end
      end
      if (in_valid && in_ready) parse_byte(in_data.path_byte, in_data.start_of_path);
    end
    parsed_pending <= parsed_q.size();
  end

endmodule

// File: dv/cip_path_segment_parser_tb.sv
// Top of the cip_path_segment_parser testbench: clock, reset, path byte
// stimulus, result back-pressure, register writes and the final verdict.
// Depends on cps_pkg, the block under test and cps_parse_checker.
`timescale 1ns / 1ps
module cip_path_segment_parser_tb;
  import cps_pkg::*;

  localparam int ITEM_TARGET    = 1350;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 150;
  localparam int DRAIN          = 8;

  localparam logic [1:0] LEN_ADDR    = 2'(32'(REG_PATH_LENGTH) * 4);
  localparam logic [2:0] SEG_LOGICAL = 3'b001;
  localparam logic [2:0] LT_SILENT   = 3'd7;
  localparam logic [1:0] FMT_8       = 2'd0;
  localparam logic [1:0] FMT_16      = 2'd1;
  localparam logic [1:0] FMT_32      = 2'd2;
  localparam logic [1:0] FMT_BAD     = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int         fail_count;
  int         parsed_pending;
  int         results_seen;
  int         ends_seen;
  logic [3:0] reasons_hit;

  int bytes_sent = 0;
  int settings_used = 0;
  int hold_requests = 0;
  int idle_cycles = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  logic [7:0] path_bytes[$];

  cip_path_segment_parser DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  cps_parse_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .errors(fail_count), .parsed_pending(parsed_pending),
    .results_seen(results_seen), .ends_seen(ends_seen), .reasons_hit(reasons_hit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("cip_path_segment_parser regression: fail");
        $finish;
      end
    end
  end

  function automatic logic [7:0] seg_byte(logic [2:0] lt, logic [1:0] fmt);
    return {SEG_LOGICAL, lt, fmt};
  endfunction

  function automatic logic [7:0] data_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // random segments, well-formed when clean; overshoot is cut at len
  function automatic void build_path(int len, bit clean);
    int n, w, pick;
    logic [1:0] f;
    path_bytes.delete();
    while (path_bytes.size() < len) begin
      pick = int'($urandom_range(0, 9));
      if (pick < 5) begin
        f = (!clean && $urandom_range(0, 15) == 0) ? FMT_BAD : 2'($urandom_range(0, 2));
        path_bytes.push_back(seg_byte(3'($urandom_range(0, 7)), f));
        if (f != FMT_BAD) begin
          w = 1 << f;
          if (w > 1 && path_bytes.size() % 2 == 1) path_bytes.push_back(data_byte());
          repeat (w) path_bytes.push_back(data_byte());
        end
      end else if (pick < 9 || clean) begin
        n = int'($urandom_range(0, (len > 120) ? 255 : 6));
        path_bytes.push_back(SYM_SEGMENT);
        path_bytes.push_back(8'(n));
        repeat (n) path_bytes.push_back(data_byte());
        if (n % 2 == 1) path_bytes.push_back(data_byte());
      end else begin
        path_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    while (path_bytes.size() > len) void'(path_bytes.pop_back());
  endfunction

  task automatic offer_byte(logic [7:0] b, logic sop);
    int gap;
    in_t item;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : int'($urandom_range(0, 7));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.path_byte = b;
    item.start_of_path = sop;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_path(logic first_sop);
    foreach (path_bytes[i]) offer_byte(path_bytes[i], (i == 0) ? first_sop : 1'b0);
  endtask

  // hold the input until every predicted result is out and the block settles
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (parsed_pending != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic program_length(logic [8:0] len);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LEN_ADDR;
    pwdata <= 32'(len);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // read back
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    settings_used++;
  endtask

  initial begin : receiver
    int gap;
    int holds_done;
    holds_done = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      gap = rx_calm ? 0 : int'($urandom_range(0, 7));
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        gap = LONG_HOLD;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int len, paths, cut;
    bit clean, hold_path;
    logic first_sop;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset length of two: one class segment, then an unknown byte and a stray one
    offer_byte(seg_byte(LT_CLASS, FMT_8), 1'b1);
    offer_byte(8'h00, 1'b0);
    offer_byte(8'hFF, 1'b1);
    offer_byte(8'h12, 1'b0);
    wait_idle();
    program_length(9'd5);
    // odd name running into the path end
    offer_byte(SYM_SEGMENT, 1'b1);
    offer_byte(8'h03, 1'b0);
    offer_byte(8'h61, 1'b0);
    offer_byte(8'h62, 1'b0);
    offer_byte(8'h63, 1'b0);
    offer_byte(seg_byte(LT_ELEMENT, FMT_BAD), 1'b1);
    // empty name, then a dotted one-char name
    offer_byte(SYM_SEGMENT, 1'b1);
    offer_byte(8'h00, 1'b0);
    offer_byte(SYM_SEGMENT, 1'b0);
    offer_byte(8'h01, 1'b0);
    offer_byte(8'hFF, 1'b0);
    offer_byte(seg_byte(LT_INSTANCE, FMT_32), 1'b1);
    offer_byte(seg_byte(LT_SILENT, FMT_8), 1'b1);
    offer_byte(8'h80, 1'b0);
    offer_byte(seg_byte(LT_CONN_PT, FMT_16), 1'b0);
    offer_byte(seg_byte(LT_ATTRIBUTE, FMT_16), 1'b1);
    offer_byte(8'h00, 1'b0);
    offer_byte(8'hFF, 1'b0);
    offer_byte(8'hFF, 1'b0);
    wait_idle();
    program_length(9'd10);
    offer_byte(SYM_SEGMENT, 1'b1);
    offer_byte(8'h04, 1'b0);
    offer_byte(8'h61, 1'b0);
    // length lowered under the open name
    wait_idle();
    program_length(9'd3);
    offer_byte(8'h62, 1'b0);

    for (int ph_no = 0; bytes_sent < ITEM_TARGET; ph_no++) begin
      wait_idle();
      hold_path = (ph_no == 4 || ph_no == 9);
      if (ph_no == 0) len = 1;
      else if (ph_no == 1) len = MAX_PATH_BYTES;
      else if (ph_no == 2) len = 2;
      else if (hold_path) len = 40;
      else if ($urandom_range(0, 9) == 0) len = int'($urandom_range(41, 120));
      else len = int'($urandom_range(1, 40));
      program_length(9'(len));
      paths = (len > 120) ? 3 : int'($urandom_range(2, 6));
      for (int p = 0; p < paths; p++) begin
        first_sop = ($urandom_range(0, 19) != 0);
        clean = (len > 120 && p == 0);
        if (hold_path && p == 0) begin
          hold_requests++;
          first_sop = 1'b1;
          clean = 1'b1;
        end
        build_path(len, clean);
        if (!clean) begin
          if (len > 120) begin
            cut = int'($urandom_range(20, 80));
            while (path_bytes.size() > cut) void'(path_bytes.pop_back());
          end else begin
            case ($urandom_range(0, 7))
              0: path_bytes[$urandom_range(0, path_bytes.size() - 1)] =
                   8'($urandom_range(0, 255));
              1: begin
                cut = int'($urandom_range(1, path_bytes.size()));
                while (path_bytes.size() > cut) void'(path_bytes.pop_back());
              end
              2: repeat ($urandom_range(1, 3)) path_bytes.push_back(8'($urandom_range(0, 255)));
              default: ;
            endcase
          end
        end
        send_path(first_sop);
        if ($urandom_range(0, 5) == 0) wait_idle();
      end
    end

    wait_idle();
    $display("covered %0d path bytes over %0d length settings, %0d long output stalls",
             bytes_sent, settings_used, hold_requests);
    $display("%0d results checked, %0d parses closed, stop reasons seen %b",
             results_seen, ends_seen, reasons_hit);
    if (parsed_pending != 0) $display("%0d results never arrived", parsed_pending);
    if (fail_count == 0 && parsed_pending == 0) begin
      $display("cip_path_segment_parser regression: pass");
    end else begin
      $display("cip_path_segment_parser regression: fail");
    end
    $finish;
  end

endmodule
